### rtl/core/qpn_pkg.sv
// shared constants for the normalized quaternion product pipeline
package qpn_pkg;

    // block-scaled component width and derived widths of squares, sum and root
    localparam int VW         = 30;
    localparam int SQ_W       = 2 * VW;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = VW + 1;
    localparam int RES_W      = SUM_W + 1;
    localparam int SQRT_STEPS = ROOT_W;

    // right operand index of each product term, per output component
    localparam logic [1:0] R_IDX [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    // terms that enter each component with a minus sign, bit t for term t
    localparam logic [3:0] NEG_T [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

### rtl/core/qpn_mult.sv
// hamilton product: sixteen term multipliers and a two-level adder tree
module qpn_mult #(
    parameter int W = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [W-1:0]   lq [4],
    input  logic signed [W-1:0]   rq [4],
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [2*W+1:0] prod [4]
);
    import qpn_pkg::*;

    localparam int PRE = (2 * W > 62) ? (2 * W - 62) : 0;
    localparam int TW  = 2 * W;
    localparam int SW  = 2 * W + 2;
    localparam int NST = 3;

    logic [NST-1:0]          vld_reg;
    logic [NST:0]            adv;
    logic [W-1:0]            la [4];
    logic [W-1:0]            ra [4];
    logic signed [TW-1:0]    term_next [16];
    logic signed [TW-1:0]    term_reg [16];
    logic signed [TW:0]      pair_next [8];
    logic signed [TW:0]      pair_reg [8];
    logic signed [SW-1:0]    prod_next [4];
    logic signed [SW-1:0]    prod_reg [4];

    // stage advance chain, a stage moves when empty or when its successor moves
    always_comb
    begin
        adv[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // operand magnitudes
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            la[i] = lq[i][W-1] ? (W'(0) - W'(lq[i])) : W'(lq[i]);
            ra[i] = rq[i][W-1] ? (W'(0) - W'(rq[i])) : W'(rq[i]);
        end
    end

    // signed product terms, magnitude truncated before the sign is applied
    always_comb
    begin
        logic [TW-1:0] mag;
        logic          neg;
        for (int c = 0; c < 4; c++)
        begin
            for (int t = 0; t < 4; t++)
            begin
                mag = TW'(la[t]) * TW'(ra[R_IDX[c][t]]);
                mag = mag >> PRE;
                neg = lq[t][W-1] ^ rq[R_IDX[c][t]][W-1] ^ NEG_T[c][t];
                term_next[4*c+t] = neg ? -$signed(mag) : $signed(mag);
            end
        end
    end

    // pair sums and final sums
    always_comb
    begin
        for (int p = 0; p < 8; p++)
        begin
            pair_next[p] = (TW+1)'(term_reg[2*p]) + (TW+1)'(term_reg[2*p+1]);
        end
        for (int c = 0; c < 4; c++)
        begin
            prod_next[c] = SW'(pair_reg[2*c]) + SW'(pair_reg[2*c+1]);
            prod[c]      = prod_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            term_reg <= term_next;
        end
        if (adv[1])
        begin
            pair_reg <= pair_next;
        end
        if (adv[2])
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

### rtl/core/qpn_scale.sv
// block scaling of the product and sum of squared scaled components
module qpn_scale #(
    parameter int W = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [2*W+1:0]         prod [4],
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [qpn_pkg::VW-1:0]        v [4],
    output logic [3:0]                    neg,
    output logic                          zero,
    output logic [qpn_pkg::SUM_W-1:0]     sum
);
    import qpn_pkg::*;

    localparam int SW  = 2 * W + 2;
    localparam int MW  = SW - 1;
    localparam int SHW = $clog2(MW + 1);
    localparam int NST = 6;

    logic [NST-1:0]    vld_reg;
    logic [NST:0]      adv;

    logic [MW-1:0]     mag0_next [4];
    logic [MW-1:0]     mag0_reg [4];
    logic [3:0]        neg0_reg;
    logic [MW-1:0]     all_or;
    logic [SHW-1:0]    len;
    logic [SHW-1:0]    sh1_next;
    logic [SHW-1:0]    sh1_reg;
    logic              zero1_reg;
    logic [MW-1:0]     mag1_reg [4];
    logic [3:0]        neg1_reg;
    logic [VW-1:0]     v2_next [4];
    logic [VW-1:0]     v2_reg [4];
    logic [3:0]        neg2_reg;
    logic              zero2_reg;
    logic [SQ_W-1:0]   sq3_next [4];
    logic [SQ_W-1:0]   sq3_reg [4];
    logic [VW-1:0]     v3_reg [4];
    logic [3:0]        neg3_reg;
    logic              zero3_reg;
    logic [SQ_W:0]     sp4_next [2];
    logic [SQ_W:0]     sp4_reg [2];
    logic [VW-1:0]     v4_reg [4];
    logic [3:0]        neg4_reg;
    logic              zero4_reg;
    logic [SUM_W-1:0]  sum5_reg;
    logic [VW-1:0]     v5_reg [4];
    logic [3:0]        neg5_reg;
    logic              zero5_reg;

    // stage advance chain
    always_comb
    begin
        adv[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // component magnitudes
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag0_next[i] = prod[i][SW-1] ? MW'(-prod[i]) : MW'(prod[i]);
        end
    end

    // leading one of the combined magnitudes sets the scaling shift
    always_comb
    begin
        all_or = mag0_reg[0] | mag0_reg[1] | mag0_reg[2] | mag0_reg[3];
        len    = '0;
        for (int j = 0; j < MW; j++)
        begin
            if (all_or[j])
            begin
                len = SHW'(j + 1);
            end
        end
        if (int'(len) > VW)
        begin
            sh1_next = SHW'(int'(len) - VW);
        end
        else
        begin
            sh1_next = '0;
        end
    end

    // scaled components, squares and their sum
    always_comb
    begin
        logic [MW-1:0] shifted;
        for (int i = 0; i < 4; i++)
        begin
            shifted     = mag1_reg[i] >> sh1_reg;
            v2_next[i]  = VW'(shifted);
            sq3_next[i] = SQ_W'(v2_reg[i]) * SQ_W'(v2_reg[i]);
        end
        sp4_next[0] = (SQ_W+1)'(sq3_reg[0]) + (SQ_W+1)'(sq3_reg[1]);
        sp4_next[1] = (SQ_W+1)'(sq3_reg[2]) + (SQ_W+1)'(sq3_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mag0_reg <= mag0_next;
            for (int i = 0; i < 4; i++)
            begin
                neg0_reg[i] <= prod[i][SW-1];
            end
        end
        if (adv[1])
        begin
            sh1_reg   <= sh1_next;
            zero1_reg <= (all_or == '0);
            mag1_reg  <= mag0_reg;
            neg1_reg  <= neg0_reg;
        end
        if (adv[2])
        begin
            v2_reg    <= v2_next;
            neg2_reg  <= neg1_reg;
            zero2_reg <= zero1_reg;
        end
        if (adv[3])
        begin
            sq3_reg   <= sq3_next;
            v3_reg    <= v2_reg;
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
        end
        if (adv[4])
        begin
            sp4_reg   <= sp4_next;
            v4_reg    <= v3_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
        end
        if (adv[5])
        begin
            sum5_reg  <= SUM_W'(sp4_reg[0]) + SUM_W'(sp4_reg[1]);
            v5_reg    <= v4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
        end
    end

    assign v    = v5_reg;
    assign neg  = neg5_reg;
    assign zero = zero5_reg;
    assign sum  = sum5_reg;

endmodule

### rtl/core/qpn_sqrt.sv
// pipelined integer square root, one result bit per stage
module qpn_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [qpn_pkg::SUM_W-1:0]   sum,
    input  logic [qpn_pkg::VW-1:0]      v_in [4],
    input  logic [3:0]                  neg_in,
    input  logic                        zero_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [qpn_pkg::ROOT_W-1:0]  root,
    output logic [qpn_pkg::VW-1:0]      v_out [4],
    output logic [3:0]                  neg_out,
    output logic                        zero_out
);
    import qpn_pkg::*;

    localparam int NST = SQRT_STEPS;

    logic [NST-1:0]    vld_reg;
    logic [NST:0]      adv;
    logic [SUM_W-1:0]  n_reg [NST];
    logic [RES_W-1:0]  res_reg [NST];
    logic [VW-1:0]     v_reg [NST][4];
    logic [3:0]        neg_reg [NST];
    logic              zero_reg [NST];

    // stage advance chain
    always_comb
    begin
        adv[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // one restoring step per stage, trial bit 4^(NST-1-i)
    for (genvar i = 0; i < NST; i++)
    begin : g_step
        logic [SUM_W-1:0]  n_src;
        logic [RES_W-1:0]  res_src;
        logic [VW-1:0]     v_src [4];
        logic [3:0]        neg_src;
        logic              zero_src;
        logic [RES_W-1:0]  trial;
        logic [SUM_W-1:0]  n_next;
        logic [RES_W-1:0]  res_next;

        if (i == 0)
        begin : g_first
            always_comb
            begin
                n_src    = sum;
                res_src  = '0;
                v_src    = v_in;
                neg_src  = neg_in;
                zero_src = zero_in;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                n_src    = n_reg[i-1];
                res_src  = res_reg[i-1];
                v_src    = v_reg[i-1];
                neg_src  = neg_reg[i-1];
                zero_src = zero_reg[i-1];
            end
        end

        always_comb
        begin
            trial = res_src + (RES_W'(1) << (2 * (NST - 1 - i)));
            if (RES_W'(n_src) >= trial)
            begin
                n_next   = n_src - SUM_W'(trial);
                res_next = (res_src >> 1) + (RES_W'(1) << (2 * (NST - 1 - i)));
            end
            else
            begin
                n_next   = n_src;
                res_next = res_src >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[i])
            begin
                n_reg[i]    <= n_next;
                res_reg[i]  <= res_next;
                v_reg[i]    <= v_src;
                neg_reg[i]  <= neg_src;
                zero_reg[i] <= zero_src;
            end
        end
    end

    assign root     = ROOT_W'(res_reg[NST-1]);
    assign v_out    = v_reg[NST-1];
    assign neg_out  = neg_reg[NST-1];
    assign zero_out = zero_reg[NST-1];

endmodule

### rtl/core/qpn_div.sv
// four-lane pipelined rounding divider, one quotient bit per stage after the setup stage
module qpn_div #(
    parameter int W = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [qpn_pkg::ROOT_W-1:0]  root,
    input  logic [qpn_pkg::VW-1:0]      v [4],
    input  logic [3:0]                  neg_in,
    input  logic                        zero_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [W-2:0]                q [4],
    output logic [3:0]                  neg_out,
    output logic                        zero_out
);
    import qpn_pkg::*;

    localparam int F   = W - 2;
    localparam int QW  = W - 1;
    localparam int NW  = VW + F + 1;
    localparam int NST = QW + 1;

    logic [NST-1:0]     vld_reg;
    logic [NST:0]       adv;
    logic [ROOT_W-1:0]  d_reg [NST];
    logic [NW-1:0]      r_reg [NST][4];
    logic [QW-1:0]      q_reg [NST][4];
    logic [3:0]         neg_reg [NST];
    logic               zero_reg [NST];
    logic [ROOT_W-1:0]  d0;
    logic [NW-1:0]      r0 [4];

    // stage advance chain
    always_comb
    begin
        adv[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // dividend with half the divisor added for round half up
    always_comb
    begin
        d0 = (root == '0) ? ROOT_W'(1) : root;
        for (int l = 0; l < 4; l++)
        begin
            r0[l] = (NW'(v[l]) << F) + NW'(d0 >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d_reg[0]    <= d0;
            r_reg[0]    <= r0;
            neg_reg[0]  <= neg_in;
            zero_reg[0] <= zero_in;
            for (int l = 0; l < 4; l++)
            begin
                q_reg[0][l] <= '0;
            end
        end
    end

    // quotient bit QW-j decided in stage j
    for (genvar j = 1; j < NST; j++)
    begin : g_bit
        logic [NW-1:0] sub;
        logic [NW-1:0] r_next [4];
        logic [QW-1:0] q_next [4];

        always_comb
        begin
            sub = NW'(d_reg[j-1]) << (QW - j);
            for (int l = 0; l < 4; l++)
            begin
                if (r_reg[j-1][l] >= sub)
                begin
                    r_next[l] = r_reg[j-1][l] - sub;
                    q_next[l] = q_reg[j-1][l] | (QW'(1) << (QW - j));
                end
                else
                begin
                    r_next[l] = r_reg[j-1][l];
                    q_next[l] = q_reg[j-1][l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[j])
            begin
                d_reg[j]    <= d_reg[j-1];
                r_reg[j]    <= r_next;
                q_reg[j]    <= q_next;
                neg_reg[j]  <= neg_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
            end
        end
    end

    assign q        = q_reg[NST-1];
    assign neg_out  = neg_reg[NST-1];
    assign zero_out = zero_reg[NST-1];

endmodule

### rtl/core/quaternion_product_normalized.sv
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined multiply, root and divide
// the 31-stage square root and the (COMPONENT_WIDTH)-stage divider dominate latency
// a stalled result is held in the output register while earlier stages keep filling
// reset clears all stage valid bits; data registers are not reset
// top level: normalized hamilton product of two quaternions
module quaternion_product_normalized #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COMPONENT_WIDTH-1:0]  left_w,
    input  logic signed [COMPONENT_WIDTH-1:0]  left_x,
    input  logic signed [COMPONENT_WIDTH-1:0]  left_y,
    input  logic signed [COMPONENT_WIDTH-1:0]  left_z,
    input  logic signed [COMPONENT_WIDTH-1:0]  right_w,
    input  logic signed [COMPONENT_WIDTH-1:0]  right_x,
    input  logic signed [COMPONENT_WIDTH-1:0]  right_y,
    input  logic signed [COMPONENT_WIDTH-1:0]  right_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [COMPONENT_WIDTH-1:0]  out_w,
    output logic signed [COMPONENT_WIDTH-1:0]  out_x,
    output logic signed [COMPONENT_WIDTH-1:0]  out_y,
    output logic signed [COMPONENT_WIDTH-1:0]  out_z,
    output logic                               zero_magnitude
);
    import qpn_pkg::*;

    localparam int W  = COMPONENT_WIDTH;
    localparam int F  = W - 2;
    localparam int SW = 2 * W + 2;
    localparam logic signed [W-1:0] UNIT     = W'(1) << F;
    localparam logic signed [W-1:0] NEG_UNIT = -(W'(1) << F);

    logic                 mult_ready;
    logic                 mult_valid;
    logic                 scale_ready;
    logic                 scale_valid;
    logic                 sqrt_ready;
    logic                 sqrt_valid;
    logic                 div_ready;
    logic                 div_valid;
    logic signed [W-1:0]  lq [4];
    logic signed [W-1:0]  rq [4];
    logic signed [SW-1:0] prod [4];
    logic [VW-1:0]        sv [4];
    logic [3:0]           sneg;
    logic                 szero;
    logic [SUM_W-1:0]     ssum;
    logic [ROOT_W-1:0]    root;
    logic [VW-1:0]        rv [4];
    logic [3:0]           rneg;
    logic                 rzero;
    logic [W-2:0]         dq [4];
    logic [3:0]           dneg;
    logic                 dzero;
    logic                 out_ready_int;
    logic                 out_valid_reg;
    logic signed [W-1:0]  out_next [4];
    logic signed [W-1:0]  out_reg [4];
    logic                 zero_reg;

    // operand gathering
    always_comb
    begin
        lq[0] = left_w;
        lq[1] = left_x;
        lq[2] = left_y;
        lq[3] = left_z;
        rq[0] = right_w;
        rq[1] = right_x;
        rq[2] = right_y;
        rq[3] = right_z;
    end

    assign in_stall = !mult_ready;

    qpn_mult #(.W(W)) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (mult_ready),
        .lq        (lq),
        .rq        (rq),
        .out_valid (mult_valid),
        .out_ready (scale_ready),
        .prod      (prod)
    );

    qpn_scale #(.W(W)) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mult_valid),
        .in_ready  (scale_ready),
        .prod      (prod),
        .out_valid (scale_valid),
        .out_ready (sqrt_ready),
        .v         (sv),
        .neg       (sneg),
        .zero      (szero),
        .sum       (ssum)
    );

    qpn_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_ready  (sqrt_ready),
        .sum       (ssum),
        .v_in      (sv),
        .neg_in    (sneg),
        .zero_in   (szero),
        .out_valid (sqrt_valid),
        .out_ready (div_ready),
        .root      (root),
        .v_out     (rv),
        .neg_out   (rneg),
        .zero_out  (rzero)
    );

    qpn_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqrt_valid),
        .in_ready  (div_ready),
        .root      (root),
        .v         (rv),
        .neg_in    (rneg),
        .zero_in   (rzero),
        .out_valid (div_valid),
        .out_ready (out_ready_int),
        .q         (dq),
        .neg_out   (dneg),
        .zero_out  (dzero)
    );

    // output register loads when empty or when the item is being taken
    assign out_ready_int = !out_valid_reg || !out_stall;

    // sign application; the quotient never exceeds one so it always fits
    always_comb
    begin
        logic [W-1:0] mag;
        for (int i = 0; i < 4; i++)
        begin
            mag = {1'b0, dq[i]};
            if (dzero)
            begin
                out_next[i] = '0;
            end
            else if (dneg[i])
            begin
                out_next[i] = $signed(W'(0) - mag);
            end
            else
            begin
                out_next[i] = $signed(mag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready_int)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready_int)
        begin
            out_reg  <= out_next;
            zero_reg <= dzero;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_w          = out_reg[0];
    assign out_x          = out_reg[1];
    assign out_y          = out_reg[2];
    assign out_z          = out_reg[3];
    assign zero_magnitude = zero_reg;

    // a zero product gives all-zero components
    a_zero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_magnitude |->
            out_w == '0 && out_x == '0 && out_y == '0 && out_z == '0)
        else $error("zero product with nonzero component");

    // a nonzero product normalizes to a nonzero result
    a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_magnitude |->
            out_w != '0 || out_x != '0 || out_y != '0 || out_z != '0)
        else $error("normalized result lost its magnitude");

    // every normalized component lies within plus or minus one
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            out_w <= UNIT && out_w >= NEG_UNIT && out_x <= UNIT && out_x >= NEG_UNIT &&
            out_y <= UNIT && out_y >= NEG_UNIT && out_z <= UNIT && out_z >= NEG_UNIT)
        else $error("normalized component beyond unit range");

endmodule

### tb/quaternion_product_normalized_tb.sv
// testbench for the normalized quaternion product: random and directed items checked in order
module quaternion_product_normalized_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 16;
    localparam int FRAC = CW - 2;
    localparam int LATENCY = CW + 41;
    localparam int N_RANDOM = 1200;

    typedef logic signed [CW-1:0] comp_t;

    typedef struct packed {
        comp_t w;
        comp_t x;
        comp_t y;
        comp_t z;
        logic  zero;
    } unit_quat_t;

    int mismatch_count = 0;

    // one line per mismatch
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    // expected normalized products, oldest first
    class product_scoreboard;
        unit_quat_t pending[$];

        function automatic longint abs64(longint a);
            return a < 0 ? -a : a;
        endfunction

        function automatic longint unsigned root_floor(longint unsigned n);
            longint unsigned res = 0;
            longint unsigned b = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function automatic unit_quat_t normalized_product(comp_t lw, comp_t lx, comp_t ly,
                comp_t lz, comp_t rw, comp_t rx, comp_t ry, comp_t rz);
            longint p[4];
            longint unsigned mag[4];
            longint unsigned v, m, sum, r, q;
            int s;
            unit_quat_t res;
            comp_t o[4];
            p[0] = lw*rw - lx*rx - ly*ry - lz*rz;
            p[1] = lw*rx + lx*rw + ly*rz - lz*ry;
            p[2] = lw*ry - lx*rz + ly*rw + lz*rx;
            p[3] = lw*rz + lx*ry - ly*rx + lz*rw;
            m = 0;
            for (int i = 0; i < 4; i++)
            begin
                mag[i] = abs64(p[i]);
                if (mag[i] > m)
                    m = mag[i];
            end
            res = '0;
            if (m == 0)
            begin
                res.zero = 1'b1;
                return res;
            end
            s = 0;
            while ((m >> s) >= (64'd1 << 30))
                s++;
            sum = 0;
            for (int i = 0; i < 4; i++)
            begin
                v = mag[i] >> s;
                sum += v * v;
            end
            r = root_floor(sum);
            if (r == 0)
                r = 1;
            for (int i = 0; i < 4; i++)
            begin
                q = (((mag[i] >> s) << FRAC) + (r >> 1)) / r;
                if (p[i] < 0)
                begin
                    if (q > (64'd1 << (CW-1)))
                        q = 64'd1 << (CW-1);
                    o[i] = comp_t'(-q);
                end
                else
                begin
                    if (q > (64'd1 << (CW-1)) - 1)
                        q = (64'd1 << (CW-1)) - 1;
                    o[i] = comp_t'(q);
                end
            end
            res.w = o[0];
            res.x = o[1];
            res.y = o[2];
            res.z = o[3];
            return res;
        endfunction

        function void note_input(comp_t lw, comp_t lx, comp_t ly, comp_t lz,
                comp_t rw, comp_t rx, comp_t ry, comp_t rz);
            pending.push_back(normalized_product(lw, lx, ly, lz, rw, rx, ry, rz));
        endfunction

        task check_result(unit_quat_t got);
            unit_quat_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected item", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.w !== want.w) report_mismatch("out_w", got.w, want.w);
            if (got.x !== want.x) report_mismatch("out_x", got.x, want.x);
            if (got.y !== want.y) report_mismatch("out_y", got.y, want.y);
            if (got.z !== want.z) report_mismatch("out_z", got.z, want.z);
            if (got.zero !== want.zero) report_mismatch("zero_magnitude", got.zero, want.zero);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    comp_t left_w = '0, left_x = '0, left_y = '0, left_z = '0;
    comp_t right_w = '0, right_x = '0, right_y = '0, right_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    comp_t out_w, out_x, out_y, out_z;
    logic zero_magnitude;

    int send_idle_pct = 32;
    int recv_idle_pct = 80;
    product_scoreboard board = new();

    quaternion_product_normalized #(.COMPONENT_WIDTH(CW)) u_dut (.*);

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // send one item, with random idle cycles before it
    task automatic send_item(input comp_t q[8]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        {left_w, left_x, left_y, left_z} <= {q[0], q[1], q[2], q[3]};
        {right_w, right_x, right_y, right_z} <= {q[4], q[5], q[6], q[7]};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7]);
    endtask

    // random component biased toward extremes, zero, unit-scale and small values
    function automatic comp_t random_comp();
        case ($urandom_range(7))
            0: return comp_t'(16'h8000);
            1: return comp_t'(16'h7fff);
            2: return '0;
            3, 4: return comp_t'($signed($urandom_range(0, 2 << FRAC)) - (1 << FRAC));
            5: return comp_t'($signed($urandom_range(0, 64)) - 32);
            default: return comp_t'($urandom);
        endcase
    endfunction

    // receiver stall and result check
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result('{out_w, out_x, out_y, out_z, zero_magnitude});

    // stimulus
    initial
    begin
        comp_t q[8];
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // directed: zeros, extremes, identity, cancelling product, tiny values
        q = '{default: '0};
        send_item(q);
        q = '{default: comp_t'(16'h8000)};
        send_item(q);
        q = '{default: comp_t'(16'h7fff)};
        send_item(q);
        q = '{comp_t'(16'h4000), 0, 0, 0, comp_t'(16'h4000), 0, 0, 0};
        send_item(q);
        q = '{1, 0, 0, 0, 0, 1, 0, 0};
        send_item(q);
        q = '{0, comp_t'(16'h8000), 0, 0, 0, comp_t'(16'h8000), 0, 0};
        send_item(q);
        q = '{1, 1, 0, 0, 1, -1, 0, 0};
        send_item(q);
        q = '{comp_t'(16'h8000), comp_t'(16'h7fff), comp_t'(16'h8000), comp_t'(16'h7fff),
              comp_t'(16'h7fff), comp_t'(16'h8000), comp_t'(16'h7fff), comp_t'(16'h8000)};
        send_item(q);
        q = '{0, 0, 0, 5, 0, 0, 0, 0};
        send_item(q);
        q = '{-1, -1, -1, -1, 1, 1, 1, 1};
        send_item(q);
        // random, in three idling phases
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 32;
            end
            else if (ph == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < N_RANDOM / 3; n++)
            begin
                foreach (q[k])
                    q[k] = random_comp();
                send_item(q);
                // occasional pause with the input idle
                if ($urandom_range(19) == 0)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    repeat ($urandom_range(LATENCY)) @(negedge clk);
                end
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // timeout
    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end
endmodule

### filelist.f
rtl/core/qpn_pkg.sv
rtl/core/qpn_mult.sv
rtl/core/qpn_scale.sv
rtl/core/qpn_sqrt.sv
rtl/core/qpn_div.sv
rtl/core/quaternion_product_normalized.sv
tb/quaternion_product_normalized_tb.sv
